/* design/igp_pkg.sv */
package igp_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned WEIGHT_W    = WEIGHT_BITS + 1;
  localparam int unsigned GAMMA_W     = 31;
  localparam int unsigned RANK_W      = 2;
  localparam int unsigned NUM_LANES   = 5;
  localparam int unsigned NUM_STAGES  = 11;

  // Lanes of the blend stages
  localparam int unsigned LANE_RHO = 0;
  localparam int unsigned LANE_EN  = 1;
  localparam int unsigned LANE_VX  = 2;
  localparam int unsigned LANE_VY  = 3;
  localparam int unsigned LANE_VZ  = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 17'd65536;
  localparam logic [GAMMA_W-1:0]  GAMMA_RESET   = 31'd109227;
  localparam logic [DATA_W-1:0]   FLOOR_RESET   = 32'd0;
  localparam logic [RANK_W-1:0]   RANK_RESET    = 2'd3;

  localparam logic [DATA_W-1:0]   INT32_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]   INT32_MIN = 32'h8000_0000;

endpackage

/* design/ideal_gas_pressure_cell_core.sv */
// Ideal-gas pressure per grid cell. Each input word carries the new and old
// density, specific total energy and three velocities of one cell (signed
// Q(31-FRAC_BITS).FRAC_BITS); the block blends them with the weight w and
// 1-w, subtracts the kinetic part 0.5*|v|^2 (components beyond grid_rank
// read as zero), and returns (gamma-1)*rho*e saturated to 32 bits and raised
// to the pressure floor, with floor_hit set when the floor took over and
// tlast copied through. All rounding is floor. The datapath is an 11-stage
// pipeline that takes one cell per clock while the output accepts; the rate
// is set by the pipeline stages themselves, the widest being the four
// parallel partial products on 32-bit halves of the final pressure
// product. Every stage has its own valid bit and its own ready, so
// bubbles collapse and new cells are still taken while a result waits on
// the output and some stage is empty. Program the registers only while no
// cell is in flight; the configuration port is always ready.
module ideal_gas_pressure_cell_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // density_new, energy_new, vel_x_new, vel_y_new, vel_z_new,
  // density_old, energy_old, vel_x_old, vel_y_old, vel_z_old (32 bits each)
  input  logic [319:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // last_cell

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // pressure_out
  output logic [0:0]  m_axis_tuser_o,   // floor_hit
  output logic        m_axis_tlast_o,   // grid_end

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [igp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NST    = igp_pkg::NUM_STAGES;
  localparam int unsigned NL     = igp_pkg::NUM_LANES;
  // kinetic energy, gas energy and product widths
  localparam int unsigned KE_W   = 63 - FRAC_BITS;
  localparam int unsigned GE_W   = KE_W + 2;
  localparam int unsigned GH_W   = GE_W - 32;
  localparam int unsigned PLH_W  = 33 + GH_W;
  localparam int unsigned PROD_W = 64 + GE_W;
  localparam int unsigned Q_W    = PROD_W - 2 * FRAC_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [igp_pkg::WEIGHT_W-1:0] weight_q;
  logic [igp_pkg::GAMMA_W-1:0]  gamma_q;
  logic signed [31:0]           floor_q;
  logic [igp_pkg::RANK_W-1:0]   rank_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= igp_pkg::WEIGHT_ONE;
      gamma_q  <= igp_pkg::GAMMA_RESET;
      floor_q  <= $signed(igp_pkg::FLOOR_RESET);
      rank_q   <= igp_pkg::RANK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        igp_pkg::CFG_WEIGHT: weight_q <= cfg_data_i[igp_pkg::WEIGHT_W-1:0];
        igp_pkg::CFG_GAMMA:  gamma_q  <= cfg_data_i[igp_pkg::GAMMA_W-1:0];
        igp_pkg::CFG_FLOOR:  floor_q  <= $signed(cfg_data_i);
        igp_pkg::CFG_RANK:   rank_q   <= cfg_data_i[igp_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the weight to one; gamma-1 in the data format.
  logic [igp_pkg::WEIGHT_W-1:0] w_eff;
  logic signed [31:0]           gm1;

  assign w_eff = (weight_q > igp_pkg::WEIGHT_ONE) ? igp_pkg::WEIGHT_ONE : weight_q;
  assign gm1   = $signed(32'({1'b0, gamma_q}) - (32'd1 << FRAC_BITS));

  // ---------------------------------------------------------------------
  // Stage valids and per-stage ready: a stage advances when it is empty or
  // the stage after it advances.
  // ---------------------------------------------------------------------
  logic [NST-1:0] vld_q, vld_d;
  logic [NST-1:0] last_q, last_d;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_axis_tready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready_o = rdy[0];

  always_comb begin
    vld_d  = vld_q;
    last_d = last_q;
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        vld_d[k]  = (k == 0) ? s_axis_tvalid_i : vld_q[k-1];
        last_d[k] = (k == 0) ? s_axis_tlast_i  : last_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  // ---------------------------------------------------------------------
  // Stage 0: new - old per lane. blend = old + floor(w*(new-old) / 2^16)
  // ---------------------------------------------------------------------
  logic signed [32:0] diff0_q [NL];
  logic signed [31:0] old0_q  [NL];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int i = 0; i < NL; i++) begin
        diff0_q[i] <= 33'($signed(s_axis_tdata_i[32*i +: 32]))
                    - 33'($signed(s_axis_tdata_i[32*(i+NL) +: 32]));
        old0_q[i]  <= $signed(s_axis_tdata_i[32*(i+NL) +: 32]);
      end
    end
  end

  // Stage 1: weight times difference
  logic signed [50:0] prod1_q [NL];
  logic signed [31:0] old1_q  [NL];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < NL; i++) begin
        prod1_q[i] <= $signed({1'b0, w_eff}) * diff0_q[i];
        old1_q[i]  <= old0_q[i];
      end
    end
  end

  // Stage 2: finish the blend, drop velocity lanes beyond the rank
  logic signed [35:0] blend_sum [NL];
  logic               lane_on   [NL];
  logic signed [31:0] x2_q      [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      blend_sum[i] = 36'(old1_q[i]) + 36'($signed(prod1_q[i][50:16]));
      lane_on[i]   = 1'b1;
    end
    lane_on[igp_pkg::LANE_VY] = (rank_q > 2'd1);
    lane_on[igp_pkg::LANE_VZ] = (rank_q > 2'd2);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < NL; i++) begin
        x2_q[i] <= lane_on[i] ? $signed(blend_sum[i][31:0]) : 32'sd0;
      end
    end
  end

  // Stage 3: velocity squares and (gamma-1)*rho
  logic [31:0]        vmag [3];
  logic [63:0]        sq3_q [3];
  logic signed [63:0] t3_q;
  logic signed [31:0] en3_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vmag[j] = x2_q[igp_pkg::LANE_VX + j][31] ? 32'(-x2_q[igp_pkg::LANE_VX + j])
                                                : 32'(x2_q[igp_pkg::LANE_VX + j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int j = 0; j < 3; j++) begin
        sq3_q[j] <= vmag[j] * vmag[j];
      end
      t3_q  <= gm1 * x2_q[igp_pkg::LANE_RHO];
      en3_q <= x2_q[igp_pkg::LANE_EN];
    end
  end

  // Stage 4: sum of squares (fits 64 bits, each square is at most 2^62)
  logic [63:0]        ksum4_q;
  logic signed [63:0] t4_q;
  logic signed [31:0] en4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      ksum4_q <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      t4_q    <= t3_q;
      en4_q   <= en3_q;
    end
  end

  // Stage 5: gas energy e = E - floor(|v|^2 / 2^(FRAC_BITS+1))
  logic [KE_W-1:0]      ke;
  logic signed [GE_W-1:0] ge5_q;
  logic signed [63:0]   t5_q;

  assign ke = ksum4_q[63:FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      ge5_q <= GE_W'(en4_q) - $signed({2'b00, ke});
      t5_q  <= t4_q;
    end
  end

  // Stage 6: four partial products of t * e on 32-bit halves
  logic [31:0]             t_lo, g_lo;
  logic signed [31:0]      t_hi;
  logic signed [GH_W-1:0]  g_hi;
  logic [63:0]             pll6_q;
  logic signed [PLH_W-1:0] plh6_q;
  logic signed [64:0]      phl6_q;
  logic signed [GE_W-1:0]  phh6_q;

  assign t_lo = t5_q[31:0];
  assign t_hi = $signed(t5_q[63:32]);
  assign g_lo = ge5_q[31:0];
  assign g_hi = $signed(ge5_q[GE_W-1:32]);

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      pll6_q <= t_lo * g_lo;
      plh6_q <= $signed({1'b0, t_lo}) * g_hi;
      phl6_q <= t_hi * $signed({1'b0, g_lo});
      phh6_q <= t_hi * g_hi;
    end
  end

  // Stage 7: middle cross terms
  logic signed [65:0]     mid7_q;
  logic [63:0]            pll7_q;
  logic signed [GE_W-1:0] phh7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      mid7_q <= 66'(plh6_q) + 66'(phl6_q);
      pll7_q <= pll6_q;
      phh7_q <= phh6_q;
    end
  end

  // Stage 8: fold the upper half of the low product into the middle terms
  logic signed [66:0]     s8_q;
  logic [31:0]            lo8_q;
  logic signed [GE_W-1:0] phh8_q;

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s8_q   <= 67'(mid7_q) + $signed({35'd0, pll7_q[63:32]});
      lo8_q  <= pll7_q[31:0];
      phh8_q <= phh7_q;
    end
  end

  // Stage 9: top word and the full exact product
  logic signed [GE_W-1:0] top9;
  logic [PROD_W-1:0]      full9_q;

  assign top9 = phh8_q + GE_W'($signed(s8_q[66:32]));

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      full9_q <= {top9, s8_q[31:0], lo8_q};
    end
  end

  // Stage 10: floor shift, saturate, apply the pressure floor
  logic [Q_W-1:0]  quot;
  logic [Q_W-32:0] quot_up;
  logic [31:0]     psat;
  logic            below;
  logic [31:0]     pres_q;
  logic            hit_q;

  assign quot    = full9_q[PROD_W-1:2*FRAC_BITS];
  assign quot_up = quot[Q_W-1:31];
  assign psat    = (&quot_up || ~|quot_up) ? quot[31:0]
                 : (quot[Q_W-1] ? igp_pkg::INT32_MIN : igp_pkg::INT32_MAX);
  assign below   = $signed(psat) < floor_q;

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      pres_q <= below ? 32'(floor_q) : psat;
      hit_q  <= below;
    end
  end

  assign m_axis_tvalid_o   = vld_q[NST-1];
  assign m_axis_tdata_o    = pres_q;
  assign m_axis_tuser_o[0] = hit_q;
  assign m_axis_tlast_o    = last_q[NST-1];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Ready drops only with every stage full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // A floored result carries the floor value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> ($signed(m_axis_tdata_o) == floor_q))
    else $error("floor flag set without the floor value");

  // An unfloored result never lies below the floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> ($signed(m_axis_tdata_o) >= floor_q))
    else $error("pressure below floor without floor flag");

endmodule
